FILE: src/ac3ed_pkg.sv
`default_nettype none

package ac3ed_pkg;

	localparam int BIN_CAPACITY_DEF = 256;
	localparam int MAX_EXPONENT_DEF = 24;

	// wide enough for 1 + 127 * 12 bins
	localparam int NEED_W = 12;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_GROUP = 1'b1;

	localparam logic [1:0] STRAT_D15   = 2'd0;
	localparam logic [1:0] STRAT_D25   = 2'd1;
	localparam logic [1:0] STRAT_D45   = 2'd2;
	localparam logic [1:0] STRAT_REUSE = 2'd3;

	typedef struct packed {
		logic       mode;
		logic [1:0] strategy;
		logic       seed_is_bin;
		logic [4:0] seed_exp;
		logic [6:0] num_groups;
		logic [6:0] packed_group;
	} ac3ed_in_t;

	typedef struct packed {
		logic [4:0] exponent;
		logic [7:0] bin_index;
		logic       last;
		logic       capacity_error;
	} ac3ed_out_t;

endpackage

`default_nettype wire

FILE: src/ac3_exponent_decoder_unit.sv
// The results of an accepted item pass through the burst register, then the result register.
// Throughput: one result per cycle while rsp_stall is low; a group item yields 3, 6 or 12
// results (group size 1, 2 or 4), drained from the per-item burst register by the single
// result register; req_stall holds the next item until the last result leaves the burst.
// Reset: no set open, running exponent 0, bin counter 0, group size 1, no result pending.
`default_nettype none

module ac3_exponent_decoder_unit #(
	parameter int BIN_CAPACITY = ac3ed_pkg::BIN_CAPACITY_DEF,
	parameter int MAX_EXPONENT = ac3ed_pkg::MAX_EXPONENT_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_stall,
	input  ac3ed_pkg::ac3ed_in_t   req,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output ac3ed_pkg::ac3ed_out_t  rsp
);
	import ac3ed_pkg::*;

	function automatic logic [4:0] clamp_add(input logic [4:0] e, input logic [2:0] m);
		logic signed [6:0] v;
		v = $signed({2'b00, e}) + $signed({4'b0000, m}) - 7'sd2;
		if (v < 7'sd0) begin
			return 5'd0;
		end else if (v > $signed(7'(MAX_EXPONENT))) begin
			return 5'(MAX_EXPONENT);
		end else begin
			return v[4:0];
		end
	endfunction

	// state
	logic [4:0] run_exp_q;
	logic [7:0] bin_cnt_q;
	logic [6:0] grp_left_q;
	logic [1:0] gsh_q;
	logic       active_q;

	// burst register: one item's results
	logic       bst_busy_q;
	logic       bst_err_q;
	logic       bst_fin_q;
	logic [1:0] bst_sh_q;
	logic [3:0] bst_idx_q;
	logic [3:0] bst_lastidx_q;
	logic [7:0] bst_base_q;
	logic [4:0] bst_exp_q [3];

	logic       rsp_valid_q;
	ac3ed_out_t rsp_q;

	logic out_load, emit, bst_end, req_acc;
	logic [1:0] dsel;

	assign out_load  = !rsp_valid_q || !rsp_stall;
	assign emit      = bst_busy_q && out_load;
	assign bst_end   = emit && (bst_idx_q == bst_lastidx_q);
	assign req_stall = bst_busy_q && !bst_end;
	assign req_acc   = req_valid && !req_stall;
	assign dsel      = 2'(bst_idx_q >> bst_sh_q);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// item decode
	logic             gen;
	logic             nx_err, nx_fin;
	logic [1:0]       nx_sh;
	logic [3:0]       nx_lastidx;
	logic [7:0]       nx_base;
	logic [4:0]       nx_e0, nx_e1, nx_e2;
	logic [4:0]       nx_run;
	logic [7:0]       nx_bin;
	logic [6:0]       nx_left;
	logic [1:0]       nx_gsh;
	logic             nx_active;
	logic [1:0]       st_sh;
	logic             st_bad;
	logic [NEED_W-1:0] needed;
	logic [2:0]       m1, m2, m3;
	logic [6:0]       rem1;
	logic [4:0]       rem2;

	always_comb begin
		gen        = 1'b0;
		nx_err     = 1'b0;
		nx_fin     = 1'b0;
		nx_sh      = 2'd0;
		nx_lastidx = 4'd0;
		nx_base    = 8'd0;
		nx_e0      = 5'd0;
		nx_e1      = 5'd0;
		nx_e2      = 5'd0;
		nx_run     = run_exp_q;
		nx_bin     = bin_cnt_q;
		nx_left    = grp_left_q;
		nx_gsh     = gsh_q;
		nx_active  = active_q;
		st_sh      = 2'd0;
		st_bad     = 1'b0;

		unique case (req.strategy)
			STRAT_D15:   st_sh = 2'd0;
			STRAT_D25:   st_sh = 2'd1;
			STRAT_D45:   st_sh = 2'd2;
			STRAT_REUSE: st_bad = 1'b1;
			default:     st_bad = 1'b1;
		endcase
		needed = ((NEED_W'(req.num_groups) * NEED_W'(3)) << st_sh)
			+ NEED_W'(req.seed_is_bin);

		priority if (req.packed_group >= 7'd125) m1 = 3'd5;
		else if (req.packed_group >= 7'd100) m1 = 3'd4;
		else if (req.packed_group >= 7'd75)  m1 = 3'd3;
		else if (req.packed_group >= 7'd50)  m1 = 3'd2;
		else if (req.packed_group >= 7'd25)  m1 = 3'd1;
		else m1 = 3'd0;
		rem1 = req.packed_group - 7'(m1 * 7'd25);
		rem2 = rem1[4:0];
		priority if (rem2 >= 5'd20) m2 = 3'd4;
		else if (rem2 >= 5'd15) m2 = 3'd3;
		else if (rem2 >= 5'd10) m2 = 3'd2;
		else if (rem2 >= 5'd5)  m2 = 3'd1;
		else m2 = 3'd0;
		m3 = 3'(rem2 - 5'(m2 * 5'd5));

		if (req.mode == MODE_START) begin
			nx_active = 1'b0;
			if (st_bad || needed > NEED_W'(BIN_CAPACITY)) begin
				nx_left = 7'd0;
				gen     = 1'b1;
				nx_err  = 1'b1;
			end else begin
				nx_gsh    = st_sh;
				nx_run    = req.seed_exp;
				nx_left   = req.num_groups;
				nx_active = (req.num_groups != 7'd0);
				nx_bin    = {7'd0, req.seed_is_bin};
				if (req.seed_is_bin) begin
					gen    = 1'b1;
					nx_e0  = req.seed_exp;
					nx_fin = (req.num_groups == 7'd0);
				end
			end
		end else if (active_q && grp_left_q != 7'd0) begin
			gen        = 1'b1;
			nx_e0      = clamp_add(run_exp_q, m1);
			nx_e1      = clamp_add(nx_e0, m2);
			nx_e2      = clamp_add(nx_e1, m3);
			nx_run     = nx_e2;
			nx_sh      = gsh_q;
			nx_lastidx = (4'd3 << gsh_q) - 4'd1;
			nx_base    = bin_cnt_q;
			nx_bin     = bin_cnt_q + (8'd3 << gsh_q);
			nx_fin     = (grp_left_q == 7'd1);
			nx_left    = grp_left_q - 7'd1;
			nx_active  = (grp_left_q != 7'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_exp_q   <= 5'd0;
			bin_cnt_q   <= 8'd0;
			grp_left_q  <= 7'd0;
			gsh_q       <= 2'd0;
			active_q    <= 1'b0;
			bst_busy_q  <= 1'b0;
			bst_idx_q   <= 4'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				run_exp_q  <= nx_run;
				bin_cnt_q  <= nx_bin;
				grp_left_q <= nx_left;
				gsh_q      <= nx_gsh;
				active_q   <= nx_active;
			end
			if (req_acc && gen) begin
				bst_busy_q <= 1'b1;
				bst_idx_q  <= 4'd0;
			end else if (bst_end) begin
				bst_busy_q <= 1'b0;
			end else if (emit) begin
				bst_idx_q <= bst_idx_q + 4'd1;
			end
			if (out_load) begin
				rsp_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && gen) begin
			bst_err_q     <= nx_err;
			bst_fin_q     <= nx_fin;
			bst_sh_q      <= nx_sh;
			bst_lastidx_q <= nx_lastidx;
			bst_base_q    <= nx_base;
			bst_exp_q[0]  <= nx_e0;
			bst_exp_q[1]  <= nx_e1;
			bst_exp_q[2]  <= nx_e2;
		end
		if (emit) begin
			rsp_q.exponent       <= bst_exp_q[dsel];
			rsp_q.bin_index      <= bst_base_q + {4'd0, bst_idx_q};
			rsp_q.last           <= bst_fin_q && (bst_idx_q == bst_lastidx_q);
			rsp_q.capacity_error <= bst_err_q;
		end
	end

endmodule

`default_nettype wire
